// ===== rtl/hbd_pkg.sv =====
package hbd_pkg;

    // Field widths
    localparam int unsigned IDX_W    = 9;
    localparam int unsigned SCORE_W  = 16;
    localparam int unsigned FM_W     = 20;   // Q10.10 feature-map values
    localparam int unsigned COORD_W  = 20;   // Q13.6 image coordinates
    localparam int unsigned GAIN_W   = 24;   // Q8.16 gains
    localparam int unsigned LIMIT_W  = 13;   // whole pixels
    localparam int unsigned CFG_W    = 24;   // widest register
    localparam int unsigned CFG_IDX_W = 3;

    // Feature-map coordinate before mapping: col/row plus offset plus size
    localparam int unsigned FMC_W    = 22;

    // Heatmap extent defaults
    localparam int unsigned MAP_WIDTH_DEF  = 512;
    localparam int unsigned MAP_HEIGHT_DEF = 512;
    localparam int unsigned MAP_DIM_W      = 13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_GAIN          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LIMIT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LIMIT    = 3'd6;

    // Register reset values
    localparam logic [SCORE_W-1:0] SCORE_THRESHOLD_RST = 16'd22938; // about 0.35
    localparam logic [GAIN_W-1:0]  GAIN_RST            = 24'd65536; // 1.0
    localparam logic [COORD_W-1:0] OFFSET_RST          = 20'd0;
    localparam logic [LIMIT_W-1:0] WIDTH_LIMIT_RST     = 13'd1920;
    localparam logic [LIMIT_W-1:0] HEIGHT_LIMIT_RST    = 13'd1080;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [FMC_W-1:0]   fm_coord_t;

endpackage

// ===== rtl/hbd_coord_map.sv =====
module hbd_coord_map (
    input  logic                          clk,
    input  hbd_pkg::fm_coord_t            coord,
    input  logic [hbd_pkg::GAIN_W-1:0]    gain,
    input  hbd_pkg::coord_t               offset,
    output hbd_pkg::coord_t               mapped
);
    import hbd_pkg::*;

    localparam int unsigned PROD_W = FMC_W + GAIN_W + 1;
    localparam int unsigned RND_W  = PROD_W + 1;
    localparam int unsigned SHIFT  = 20;
    localparam int unsigned SHR_W  = RND_W - SHIFT;
    localparam int unsigned SUM_W  = SHR_W + 1;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(524287);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(524288);

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [RND_W-1:0]  rnd;
    logic signed [SHR_W-1:0]  shr;
    logic signed [SUM_W-1:0]  sum;

    // Q10.10 times Q8.16 gives Q.26
    assign prod_next = PROD_W'(coord) * PROD_W'($signed({1'b0, gain}));

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Round half up to Q13.6, add offset, saturate
    always_comb
    begin
        rnd = RND_W'(prod_reg) + RND_W'(1 << (SHIFT - 1));
        shr = rnd[RND_W-1:SHIFT];
        sum = SUM_W'(shr) + SUM_W'(offset);
        if (sum > SAT_MAX)
        begin
            mapped = coord_t'(SAT_MAX[COORD_W-1:0]);
        end
        else if (sum < SAT_MIN)
        begin
            mapped = coord_t'(SAT_MIN[COORD_W-1:0]);
        end
        else
        begin
            mapped = sum[COORD_W-1:0];
        end
    end

endmodule

// ===== rtl/detection_heatmap_box_decoder_top.sv =====
// Heatmap box decoder.
// A heatmap cell (row, column, score, four sizes, two sub-cell offsets) is
// transferred in at a rising edge where start is high and busy is low. busy
// never rises: one cell can be taken every clock cycle.
// A cell whose score is strictly above the threshold and that lies inside the
// heatmap gives one box in image pixels (Q13.6); the others give nothing.
// A box appears on the box_* ports, with score, src_row and src_col, for one
// cycle with done high, after the input, product and result registers, and is
// transferred at the edge that ends that cycle. Every cycle may carry a result.
// A box whose left edge lies beyond the width limit or whose top lies beyond the
// height limit is dropped; right and bottom are clipped to the limits.
// The receiver cannot hold results off; each is transferred in its cycle.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must do so
// only while no cell is in flight, which the block does not enforce. Reset
// clears the pipeline and loads the default registers.
module detection_heatmap_box_decoder_top #(
    parameter int unsigned MAP_WIDTH  = hbd_pkg::MAP_WIDTH_DEF,
    parameter int unsigned MAP_HEIGHT = hbd_pkg::MAP_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_we,
    input  logic [hbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbd_pkg::CFG_W-1:0]        cfg_data,
    // cell input
    input  logic                             start,
    output logic                             busy,
    input  logic [hbd_pkg::IDX_W-1:0]        cell_row,
    input  logic [hbd_pkg::IDX_W-1:0]        cell_col,
    input  logic [hbd_pkg::SCORE_W-1:0]      score,
    input  logic signed [hbd_pkg::FM_W-1:0]  size_left,
    input  logic signed [hbd_pkg::FM_W-1:0]  size_top,
    input  logic signed [hbd_pkg::FM_W-1:0]  size_right,
    input  logic signed [hbd_pkg::FM_W-1:0]  size_bottom,
    input  logic signed [hbd_pkg::FM_W-1:0]  offset_x,
    input  logic signed [hbd_pkg::FM_W-1:0]  offset_y,
    // box output
    output logic                             done,
    output hbd_pkg::coord_t                  box_left,
    output hbd_pkg::coord_t                  box_top,
    output hbd_pkg::coord_t                  box_right,
    output hbd_pkg::coord_t                  box_bottom,
    output logic [hbd_pkg::SCORE_W-1:0]      box_score,
    output logic [hbd_pkg::IDX_W-1:0]        src_row,
    output logic [hbd_pkg::IDX_W-1:0]        src_col
);
    import hbd_pkg::*;

    localparam logic [MAP_DIM_W-1:0] MAP_W_LIM = MAP_DIM_W'(MAP_WIDTH);
    localparam logic [MAP_DIM_W-1:0] MAP_H_LIM = MAP_DIM_W'(MAP_HEIGHT);

    // Configuration registers
    logic [SCORE_W-1:0] thr_reg;
    logic [GAIN_W-1:0]  x_gain_reg;
    coord_t             x_off_reg;
    logic [GAIN_W-1:0]  y_gain_reg;
    coord_t             y_off_reg;
    logic [LIMIT_W-1:0] w_lim_reg;
    logic [LIMIT_W-1:0] h_lim_reg;

    // Stage 1: input register
    logic                    s1_valid_reg;
    logic [IDX_W-1:0]        s1_row_reg;
    logic [IDX_W-1:0]        s1_col_reg;
    logic [SCORE_W-1:0]      s1_score_reg;
    logic signed [FM_W-1:0]  s1_sl_reg;
    logic signed [FM_W-1:0]  s1_st_reg;
    logic signed [FM_W-1:0]  s1_sr_reg;
    logic signed [FM_W-1:0]  s1_sb_reg;
    logic signed [FM_W-1:0]  s1_ox_reg;
    logic signed [FM_W-1:0]  s1_oy_reg;

    // Stage 2: product register side data
    logic                    s2_valid_next;
    logic                    s2_valid_reg;
    logic [IDX_W-1:0]        s2_row_reg;
    logic [IDX_W-1:0]        s2_col_reg;
    logic [SCORE_W-1:0]      s2_score_reg;

    fm_coord_t cx;
    fm_coord_t cy;
    fm_coord_t left_fm;
    fm_coord_t top_fm;
    fm_coord_t right_fm;
    fm_coord_t bottom_fm;

    coord_t left_px;
    coord_t top_px;
    coord_t right_px;
    coord_t bottom_px;
    coord_t wl;
    coord_t hl;
    logic   keep;

    logic   done_reg;
    coord_t left_reg;
    coord_t top_reg;
    coord_t right_reg;
    coord_t bottom_reg;
    logic [SCORE_W-1:0] score_reg;
    logic [IDX_W-1:0]   row_reg;
    logic [IDX_W-1:0]   col_reg;

    assign busy = 1'b0;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= SCORE_THRESHOLD_RST;
            x_gain_reg <= GAIN_RST;
            x_off_reg  <= OFFSET_RST;
            y_gain_reg <= GAIN_RST;
            y_off_reg  <= OFFSET_RST;
            w_lim_reg  <= WIDTH_LIMIT_RST;
            h_lim_reg  <= HEIGHT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCORE_THRESHOLD: thr_reg    <= cfg_data[SCORE_W-1:0];
                REG_X_GAIN:          x_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_X_OFFSET:        x_off_reg  <= cfg_data[COORD_W-1:0];
                REG_Y_GAIN:          y_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_Y_OFFSET:        y_off_reg  <= cfg_data[COORD_W-1:0];
                REG_WIDTH_LIMIT:     w_lim_reg  <= cfg_data[LIMIT_W-1:0];
                REG_HEIGHT_LIMIT:    h_lim_reg  <= cfg_data[LIMIT_W-1:0];
                default:             ;
            endcase
        end
    end

    // Valid flags: input register, product register and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s2_valid_next;
            done_reg     <= s2_valid_reg && keep;
        end
    end

    // Input register: payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s1_row_reg   <= cell_row;
            s1_col_reg   <= cell_col;
            s1_score_reg <= score;
            s1_sl_reg    <= size_left;
            s1_st_reg    <= size_top;
            s1_sr_reg    <= size_right;
            s1_sb_reg    <= size_bottom;
            s1_ox_reg    <= offset_x;
            s1_oy_reg    <= offset_y;
        end
    end

    // Cell filter and feature-map box edges
    always_comb
    begin
        s2_valid_next = s1_valid_reg
                        && ({4'b0, s1_col_reg} < MAP_W_LIM)
                        && ({4'b0, s1_row_reg} < MAP_H_LIM)
                        && (s1_score_reg > thr_reg);
        cx = $signed({3'b0, s1_col_reg, 10'b0}) + FMC_W'(s1_ox_reg);
        cy = $signed({3'b0, s1_row_reg, 10'b0}) + FMC_W'(s1_oy_reg);
        left_fm   = cx - FMC_W'(s1_sl_reg);
        top_fm    = cy - FMC_W'(s1_st_reg);
        right_fm  = cx + FMC_W'(s1_sr_reg);
        bottom_fm = cy + FMC_W'(s1_sb_reg);
    end

    always_ff @(posedge clk)
    begin
        s2_row_reg   <= s1_row_reg;
        s2_col_reg   <= s1_col_reg;
        s2_score_reg <= s1_score_reg;
    end

    // Four mapping units, product registered inside
    hbd_coord_map u_map_left (
        .clk    (clk),
        .coord  (left_fm),
        .gain   (x_gain_reg),
        .offset (x_off_reg),
        .mapped (left_px)
    );

    hbd_coord_map u_map_top (
        .clk    (clk),
        .coord  (top_fm),
        .gain   (y_gain_reg),
        .offset (y_off_reg),
        .mapped (top_px)
    );

    hbd_coord_map u_map_right (
        .clk    (clk),
        .coord  (right_fm),
        .gain   (x_gain_reg),
        .offset (x_off_reg),
        .mapped (right_px)
    );

    hbd_coord_map u_map_bottom (
        .clk    (clk),
        .coord  (bottom_fm),
        .gain   (y_gain_reg),
        .offset (y_off_reg),
        .mapped (bottom_px)
    );

    // Drop test against limits in Q13.6
    always_comb
    begin
        wl   = $signed({1'b0, w_lim_reg, 6'b0});
        hl   = $signed({1'b0, h_lim_reg, 6'b0});
        keep = !(left_px > wl) && !(top_px > hl);
    end

    // Result register with clipping
    always_ff @(posedge clk)
    begin
        left_reg   <= left_px;
        top_reg    <= top_px;
        right_reg  <= (right_px > wl) ? wl : right_px;
        bottom_reg <= (bottom_px > hl) ? hl : bottom_px;
        score_reg  <= s2_score_reg;
        row_reg    <= s2_row_reg;
        col_reg    <= s2_col_reg;
    end

    assign done       = done_reg;
    assign box_left   = left_reg;
    assign box_top    = top_reg;
    assign box_right  = right_reg;
    assign box_bottom = bottom_reg;
    assign box_score  = score_reg;
    assign src_row    = row_reg;
    assign src_col    = col_reg;

endmodule

// ===== tb/sv/detection_heatmap_box_decoder_top_tb.sv =====
module detection_heatmap_box_decoder_top_tb;

    import hbd_pkg::*;

    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [SCORE_W-1:0]        score_t;
    typedef logic signed [FM_W-1:0]    fm_t;
    typedef logic [GAIN_W-1:0]         gain_t;
    typedef logic [LIMIT_W-1:0]        limit_t;
    typedef logic [CFG_W-1:0]          cfg_word_t;

    typedef struct {
        idx_t   row;
        idx_t   col;
        score_t score;
        fm_t    size_left;
        fm_t    size_top;
        fm_t    size_right;
        fm_t    size_bottom;
        fm_t    offset_x;
        fm_t    offset_y;
    } cell_t;

    typedef struct {
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
        score_t score;
        idx_t   row;
        idx_t   col;
    } box_t;

    // Index past the last register; writes to it must have no effect
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam int     PIPE_LAT    = 3;
    localparam int     CYCLE_LIMIT = 200000;
    localparam longint COORD_HI    = 524287;
    localparam longint COORD_LO    = -524288;
    localparam fm_t    FM_MAX      = 20'sh7FFFF;
    localparam fm_t    FM_MIN      = 20'sh80000;
    localparam coord_t OFF_MAX     = 20'sh7FFFF;
    localparam coord_t OFF_MIN     = 20'sh80000;
    localparam gain_t  GAIN_MAX    = 24'hFFFFFF;
    localparam gain_t  GAIN_ZERO   = 24'd0;
    localparam limit_t LIMIT_MAX   = 13'd8191;
    localparam limit_t LIMIT_ZERO  = 13'd0;
    localparam score_t SCORE_MAX   = 16'hFFFF;
    localparam score_t SCORE_ZERO  = 16'd0;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    cfg_word_t       cfg_data;
    logic            start;
    logic            busy;
    idx_t            cell_row;
    idx_t            cell_col;
    score_t          score;
    fm_t             size_left;
    fm_t             size_top;
    fm_t             size_right;
    fm_t             size_bottom;
    fm_t             offset_x;
    fm_t             offset_y;
    logic            done;
    coord_t          box_left;
    coord_t          box_top;
    coord_t          box_right;
    coord_t          box_bottom;
    score_t          box_score;
    idx_t            src_row;
    idx_t            src_col;

    // Local copy of the register file
    score_t          thr_q;
    gain_t           x_gain_q;
    coord_t          x_off_q;
    gain_t           y_gain_q;
    coord_t          y_off_q;
    limit_t          width_lim_q;
    limit_t          height_lim_q;

    box_t            pending_boxes[$];
    box_t            oldest_box;
    int              idle_pct;
    int              fail_count;
    int              cells_sent;
    int              boxes_checked;
    int              reg_writes;
    int              cycle_count;

    detection_heatmap_box_decoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .score       (score),
        .size_left   (size_left),
        .size_top    (size_top),
        .size_right  (size_right),
        .size_bottom (size_bottom),
        .offset_x    (offset_x),
        .offset_y    (offset_y),
        .done        (done),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_right   (box_right),
        .box_bottom  (box_bottom),
        .box_score   (box_score),
        .src_row     (src_row),
        .src_col     (src_col)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run-length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("detection_heatmap_box_decoder_top: mismatch");
            $finish;
        end
    end

    // Q10.10 feature-map coordinate to saturated Q13.6 pixels, ties rounded up
    function automatic longint to_pixels(longint fm, longint gain, longint off);
        longint r;
        r = ((fm * gain + 64'sd524288) >>> 20) + off;
        if (r > COORD_HI)
            r = COORD_HI;
        else if (r < COORD_LO)
            r = COORD_LO;
        return r;
    endfunction

    // Box expected for one cell; returns 0 when the cell yields nothing
    function automatic bit decode_box(input cell_t c, output box_t b);
        longint cx, cy, l, t, r, bt, wl, hl;
        b = '{default: '0};
        if (c.col >= MAP_WIDTH_DEF || c.row >= MAP_HEIGHT_DEF)
            return 1'b0;
        if (!(c.score > thr_q))
            return 1'b0;
        cx = longint'(c.col) * 1024 + longint'(c.offset_x);
        cy = longint'(c.row) * 1024 + longint'(c.offset_y);
        l  = to_pixels(cx - longint'(c.size_left), x_gain_q, x_off_q);
        t  = to_pixels(cy - longint'(c.size_top), y_gain_q, y_off_q);
        r  = to_pixels(cx + longint'(c.size_right), x_gain_q, x_off_q);
        bt = to_pixels(cy + longint'(c.size_bottom), y_gain_q, y_off_q);
        wl = longint'(width_lim_q) * 64;
        hl = longint'(height_lim_q) * 64;
        if (l > wl || t > hl)
            return 1'b0;
        if (r > wl)
            r = wl;
        if (bt > hl)
            bt = hl;
        b.left   = coord_t'(l);
        b.top    = coord_t'(t);
        b.right  = coord_t'(r);
        b.bottom = coord_t'(bt);
        b.score  = c.score;
        b.row    = c.row;
        b.col    = c.col;
        return 1'b1;
    endfunction

    function automatic cell_t mk_cell(idx_t row, idx_t col, score_t s, fm_t sl, fm_t st,
                                      fm_t sr, fm_t sb, fm_t ox, fm_t oy);
        cell_t c;
        c = '{row, col, s, sl, st, sr, sb, ox, oy};
        return c;
    endfunction

    // Plausible cells: sub-cell offsets and modest sizes, mostly positive; else raw noise
    function automatic cell_t random_cell(bit plausible);
        cell_t c;
        c.row = idx_t'($urandom);
        c.col = idx_t'($urandom);
        if (plausible)
        begin
            c.score       = score_t'($urandom);
            if ($urandom_range(7) == 0)
                c.score = thr_q + score_t'($urandom_range(1));
            c.size_left   = fm_t'($urandom_range(40960));
            c.size_top    = fm_t'($urandom_range(40960));
            c.size_right  = fm_t'($urandom_range(40960));
            c.size_bottom = fm_t'($urandom_range(40960));
            if ($urandom_range(15) == 0)
                c.size_left = -fm_t'($urandom_range(4096));
            if ($urandom_range(15) == 0)
                c.size_bottom = -fm_t'($urandom_range(4096));
            c.offset_x    = fm_t'($urandom_range(2047)) - 20'sd1024;
            c.offset_y    = fm_t'($urandom_range(2047)) - 20'sd1024;
        end
        else
        begin
            c.score       = score_t'($urandom);
            c.size_left   = fm_t'($urandom);
            c.size_top    = fm_t'($urandom);
            c.size_right  = fm_t'($urandom);
            c.size_bottom = fm_t'($urandom);
            c.offset_x    = fm_t'($urandom);
            c.offset_y    = fm_t'($urandom);
        end
        return c;
    endfunction

    // One register write; cfg_we is left high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        reg_writes++;
        case (idx)
            REG_SCORE_THRESHOLD: thr_q        = data[SCORE_W-1:0];
            REG_X_GAIN:          x_gain_q     = data[GAIN_W-1:0];
            REG_X_OFFSET:        x_off_q      = data[COORD_W-1:0];
            REG_Y_GAIN:          y_gain_q     = data[GAIN_W-1:0];
            REG_Y_OFFSET:        y_off_q      = data[COORD_W-1:0];
            REG_WIDTH_LIMIT:     width_lim_q  = data[LIMIT_W-1:0];
            REG_HEIGHT_LIMIT:    height_lim_q = data[LIMIT_W-1:0];
            default:             ;
        endcase
    endtask

    // Full register set; unused upper data bits carry junk, index 7 gets junk too
    task automatic apply_config(score_t thr, gain_t xg, coord_t xo, gain_t yg, coord_t yo,
                                limit_t wl, limit_t hl);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_SCORE_THRESHOLD, {junk[7:0], thr});
        write_reg(REG_X_GAIN, xg);
        write_reg(REG_X_OFFSET, {junk[11:8], xo});
        write_reg(REG_Y_GAIN, yg);
        write_reg(REG_Y_OFFSET, {junk[15:12], yo});
        write_reg(REG_WIDTH_LIMIT, {junk[26:16], wl});
        write_reg(REG_HEIGHT_LIMIT, {junk[31:21], hl});
        write_reg(REG_UNUSED, cfg_word_t'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_realistic_config();
        apply_config(score_t'($urandom_range(50000, 5000)),
                     gain_t'($urandom_range(524288, 16384)),
                     coord_t'($urandom_range(8192)) - 20'sd4096,
                     gain_t'($urandom_range(524288, 16384)),
                     coord_t'($urandom_range(8192)) - 20'sd4096,
                     limit_t'($urandom_range(8191, 64)),
                     limit_t'($urandom_range(8191, 64)));
    endtask

    // Transfer one cell in, record the expected box, then maybe idle
    task automatic send_cell(cell_t c);
        box_t b;
        start       <= 1'b1;
        cell_row    <= c.row;
        cell_col    <= c.col;
        score       <= c.score;
        size_left   <= c.size_left;
        size_top    <= c.size_top;
        size_right  <= c.size_right;
        size_bottom <= c.size_bottom;
        offset_x    <= c.offset_x;
        offset_y    <= c.offset_y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        cells_sent++;
        if (decode_box(c, b))
            pending_boxes = {pending_boxes, b};
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Stop sending, wait for every box, then let dropped cells clear the pipe
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_boxes.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2)
            @(posedge clk);
    endtask

    task automatic check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // Result checker: every done cycle is one transfer out
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_boxes.size() == 0)
            begin
                $error("box transfer with no box expected");
                fail_count++;
            end
            else
            begin
                oldest_box = pending_boxes.pop_front();
                boxes_checked++;
                check_field("box_left", oldest_box.left, box_left);
                check_field("box_top", oldest_box.top, box_top);
                check_field("box_right", oldest_box.right, box_right);
                check_field("box_bottom", oldest_box.bottom, box_bottom);
                check_field("box_score", oldest_box.score, box_score);
                check_field("src_row", oldest_box.row, src_row);
                check_field("src_col", oldest_box.col, src_col);
            end
        end
    end

    // Threshold edge, field extremes and rounding ties under reset registers
    task automatic test_threshold_and_extremes();
        send_cell(mk_cell(9'd0, 9'd0, thr_q, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0));
        send_cell(mk_cell(9'd3, 9'd4, thr_q + 16'd1, 20'sd512, 20'sd512, 20'sd512, 20'sd512,
                          20'sd0, 20'sd0));
        send_cell(mk_cell(9'd7, 9'd9, SCORE_ZERO, 20'sd100, 20'sd100, 20'sd100, 20'sd100,
                          20'sd0, 20'sd0));
        send_cell(mk_cell(9'd7, 9'd9, SCORE_MAX, 20'sd100, 20'sd100, 20'sd100, 20'sd100,
                          20'sd0, 20'sd0));
        send_cell(mk_cell(9'd511, 9'd511, SCORE_MAX, FM_MAX, FM_MAX, FM_MAX, FM_MAX,
                          FM_MAX, FM_MAX));
        send_cell(mk_cell(9'd0, 9'd0, SCORE_MAX, FM_MIN, FM_MIN, FM_MIN, FM_MIN,
                          FM_MIN, FM_MIN));
        send_cell(mk_cell(9'd511, 9'd0, SCORE_MAX, FM_MAX, FM_MIN, FM_MAX, FM_MIN,
                          FM_MIN, FM_MAX));
        // half-pixel ties round towards plus infinity
        send_cell(mk_cell(9'd0, 9'd0, SCORE_MAX, 20'sd0, 20'sd0, 20'sd0, 20'sd0,
                          20'sd8, -20'sd8));
        send_cell(mk_cell(9'd0, 9'd0, SCORE_MAX, 20'sd0, 20'sd0, 20'sd0, 20'sd0,
                          -20'sd24, 20'sd24));
        send_cell(mk_cell(9'd0, 9'd1, SCORE_MAX, 20'sd1031, 20'sd7, -20'sd9, 20'sd9,
                          20'sd0, 20'sd0));
        wait_idle();
    endtask

    // Drop test at and just past the limits, clipping of right and bottom
    task automatic test_drop_and_clip();
        apply_config(SCORE_THRESHOLD_RST, GAIN_RST, OFFSET_RST, GAIN_RST, OFFSET_RST,
                     13'd100, 13'd50);
        send_cell(mk_cell(9'd10, 9'd100, SCORE_MAX, 20'sd0, 20'sd0, 20'sd4096, 20'sd0,
                          20'sd0, 20'sd0));
        send_cell(mk_cell(9'd10, 9'd100, SCORE_MAX, 20'sd0, 20'sd0, 20'sd0, 20'sd0,
                          20'sd16, 20'sd0));
        send_cell(mk_cell(9'd50, 9'd10, SCORE_MAX, 20'sd0, 20'sd0, 20'sd0, 20'sd4096,
                          20'sd0, 20'sd0));
        send_cell(mk_cell(9'd50, 9'd10, SCORE_MAX, 20'sd0, 20'sd0, 20'sd0, 20'sd0,
                          20'sd0, 20'sd16));
        send_cell(mk_cell(9'd10, 9'd10, SCORE_MAX, 20'sd2048, 20'sd2048, 20'sd102400,
                          20'sd102400, 20'sd0, 20'sd0));
        wait_idle();
    endtask

    // Largest gain: saturation on both sides, clip of a saturated edge
    task automatic test_saturation();
        apply_config(SCORE_ZERO, GAIN_MAX, OFFSET_RST, GAIN_MAX, OFFSET_RST,
                     LIMIT_MAX, LIMIT_MAX);
        send_cell(mk_cell(9'd0, 9'd0, 16'd1, 20'sd0, 20'sd0, FM_MAX, FM_MAX,
                          20'sd0, 20'sd0));
        send_cell(mk_cell(9'd0, 9'd0, 16'd1, FM_MAX, FM_MAX, 20'sd0, 20'sd0,
                          20'sd0, 20'sd0));
        send_cell(mk_cell(9'd1, 9'd1, 16'd1, 20'sd0, 20'sd0, 20'sd0, 20'sd0,
                          20'sd0, 20'sd0));
        wait_idle();
    endtask

    // Register extremes and fully random register words, each with a burst of cells
    task automatic test_config_sweep();
        for (int k = 0; k < 6; k++)
        begin
            case (k)
                0: apply_config(SCORE_ZERO, GAIN_ZERO, OFF_MIN, GAIN_ZERO, OFF_MIN,
                                LIMIT_ZERO, LIMIT_ZERO);
                1: apply_config(SCORE_MAX, GAIN_MAX, OFF_MAX, GAIN_MAX, OFF_MAX,
                                LIMIT_MAX, LIMIT_MAX);
                2: apply_config(SCORE_ZERO, GAIN_MAX, OFF_MAX, GAIN_ZERO, OFF_MIN,
                                LIMIT_MAX, LIMIT_ZERO);
                default: apply_config(score_t'($urandom), gain_t'($urandom),
                                      coord_t'($urandom), gain_t'($urandom),
                                      coord_t'($urandom), limit_t'($urandom),
                                      limit_t'($urandom));
            endcase
            for (int n = 0; n < 35; n++)
                send_cell(random_cell($urandom_range(3) != 0));
            wait_idle();
        end
    endtask

    // Mostly plausible cells at a given sender idle rate, drained halfway
    task automatic test_random_traffic(int pct, int count);
        idle_pct = pct;
        for (int half = 0; half < 2; half++)
        begin
            random_realistic_config();
            for (int n = 0; n < count / 2; n++)
                send_cell(random_cell($urandom_range(9) != 0));
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        start       <= 1'b0;
        cell_row    <= '0;
        cell_col    <= '0;
        score       <= '0;
        size_left   <= '0;
        size_top    <= '0;
        size_right  <= '0;
        size_bottom <= '0;
        offset_x    <= '0;
        offset_y    <= '0;
        thr_q        = SCORE_THRESHOLD_RST;
        x_gain_q     = GAIN_RST;
        x_off_q      = OFFSET_RST;
        y_gain_q     = GAIN_RST;
        y_off_q      = OFFSET_RST;
        width_lim_q  = WIDTH_LIMIT_RST;
        height_lim_q = HEIGHT_LIMIT_RST;
        idle_pct      = 12;
        fail_count    = 0;
        cells_sent    = 0;
        boxes_checked = 0;
        reg_writes    = 0;
        cycle_count   = 0;

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_threshold_and_extremes();
        test_drop_and_clip();
        test_saturation();
        test_config_sweep();
        test_random_traffic(12, 580);
        test_random_traffic(80, 580);
        test_random_traffic(0, 580);
        wait_idle();

        $display("Run covered %0d cell transfers and %0d checked boxes over %0d register writes",
                 cells_sent, boxes_checked, reg_writes);
        $display("including threshold, drop, clip, rounding and saturation corners");
        if (fail_count == 0)
            $display("detection_heatmap_box_decoder_top: match");
        else
            $display("detection_heatmap_box_decoder_top: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hbd_pkg.sv
rtl/hbd_coord_map.sv
rtl/detection_heatmap_box_decoder_top.sv
tb/sv/detection_heatmap_box_decoder_top_tb.sv
